// ===== sv/ole_pkg.sv =====
`default_nettype none

package ole_pkg;

  // Default list capacity in 64-bit words.
  localparam int DEPTH_DEF = 256;

  // Fixed field widths of the stream payloads.
  localparam int OP_W    = 4;
  localparam int WORD_W  = 64;
  localparam int FIELD_W = 9;

  // Packed payload widths, padded up to whole bytes.
  localparam int IN_BITS      = OP_W + WORD_W + FIELD_W;
  localparam int OUT_BITS     = 1 + WORD_W + 2 * FIELD_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 4'd0,
    OP_INSERT  = 4'd1,
    OP_GET     = 4'd2,
    OP_DELETE  = 4'd3,
    OP_CLEAR   = 4'd4,
    OP_START   = 4'd5,
    OP_NEXT    = 4'd6,
    OP_SAVE    = 4'd7,
    OP_RESTORE = 4'd8
  } op_e;

endpackage

`default_nettype wire

// ===== sv/ole_mem.sv =====
`default_nettype none

module ole_mem #(
  parameter int DEPTH = ole_pkg::DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [ole_pkg::WORD_W-1:0] wdata_i,
  input  wire logic [AW-1:0]              raddr_i,
  output logic      [ole_pkg::WORD_W-1:0] rdata_o
);
  import ole_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // The read port samples every cycle; data shows in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/ole_seq.sv =====
`default_nettype none

module ole_seq #(
  parameter int DEPTH = ole_pkg::DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Command side
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ole_pkg::OP_W-1:0]    in_opcode_i,
  input  wire logic [ole_pkg::WORD_W-1:0]  in_value_i,
  input  wire logic [ole_pkg::FIELD_W-1:0] in_index_i,
  // Result side
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             out_ok_o,
  output logic      [ole_pkg::WORD_W-1:0]  out_item_o,
  output logic      [ole_pkg::FIELD_W-1:0] out_saved_o,
  output logic      [ole_pkg::FIELD_W-1:0] out_count_o,
  // Memory port
  output logic                             mem_we_o,
  output logic      [AW-1:0]               mem_waddr_o,
  output logic      [ole_pkg::WORD_W-1:0]  mem_wdata_o,
  output logic      [AW-1:0]               mem_raddr_o,
  input  wire logic [ole_pkg::WORD_W-1:0]  mem_rdata_i
);
  import ole_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int PW = XW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT_UP,
    ST_INS_WR,
    ST_SEARCH,
    ST_DEL_START,
    ST_SHIFT_DN,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [WORD_W-1:0]   value_q, value_d;
  logic [FIELD_W-1:0]  idx_q, idx_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       cur_q, cur_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic                res_ok_q, res_ok_d;
  logic [WORD_W-1:0]   res_item_q, res_item_d;
  logic [FIELD_W-1:0]  res_saved_q, res_saved_d;
  logic                out_valid_q, out_valid_d;
  logic                out_ok_q, out_ok_d;
  logic [WORD_W-1:0]   out_item_q, out_item_d;
  logic [FIELD_W-1:0]  out_saved_q, out_saved_d;
  logic [FIELD_W-1:0]  out_count_q, out_count_d;

  // Shared pointer unit: the index, cursor and pointer comparisons and steps run on these widened values.
  logic [PW-1:0] idx_p, cnt_p, cur_p, ptr_p;
  logic [PW-1:0] cur_nxt_p, cur_rst_p;

  assign idx_p     = PW'(idx_q);
  assign cnt_p     = PW'(cnt_q);
  assign cur_p     = PW'(cur_q);
  assign ptr_p     = PW'(ptr_q);
  assign cur_nxt_p = (cur_p < DEPTH_P) ? cur_p + PW'(1) : cur_p;
  assign cur_rst_p = (idx_p > DEPTH_P) ? DEPTH_P : idx_p;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    value_d     = value_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    ptr_d       = ptr_q;
    res_ok_d    = res_ok_q;
    res_item_d  = res_item_q;
    res_saved_d = res_saved_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_ok_d    = out_ok_q;
    out_item_d  = out_item_q;
    out_saved_d = out_saved_q;
    out_count_d = out_count_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(ptr_q);
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d        = op_e'(in_opcode_i);
          value_d     = in_value_i;
          idx_d       = in_index_i;
          res_ok_d    = 1'b0;
          res_item_d  = '0;
          res_saved_d = '0;
          state_d     = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_DONE;
        unique case (op_q)
          OP_APPEND: begin
            if (cnt_q < DEPTH_C) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = AW'(cnt_q);
              mem_wdata_o = value_q;
              cnt_d       = cnt_q + CW'(1);
              res_ok_d    = 1'b1;
            end
          end
          OP_INSERT: begin
            if (idx_p <= cnt_p && cnt_q < DEPTH_C) begin
              if (idx_p == cnt_p) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AW'(idx_q);
                mem_wdata_o = value_q;
                cnt_d       = cnt_q + CW'(1);
                res_ok_d    = 1'b1;
              end else begin
                mem_raddr_o = AW'(cnt_p - PW'(1));
                ptr_d       = AW'(cnt_q);
                state_d     = ST_SHIFT_UP;
              end
            end
          end
          OP_GET: begin
            if (idx_p < cnt_p) begin
              mem_raddr_o = AW'(idx_q);
              res_ok_d    = 1'b1;
              state_d     = ST_RD_WAIT;
            end
          end
          OP_DELETE: begin
            if (cnt_q != '0 && idx_p < cnt_p) begin
              if (value_q != '0) begin
                mem_raddr_o = '0;
                ptr_d       = '0;
                state_d     = ST_SEARCH;
              end else begin
                ptr_d   = AW'(idx_q);
                state_d = ST_DEL_START;
              end
            end
          end
          OP_CLEAR: begin
            cnt_d    = '0;
            res_ok_d = 1'b1;
          end
          OP_START, OP_SAVE: begin
            if (op_q == OP_SAVE) begin
              res_saved_d = FIELD_W'(cur_q);
            end
            if (cnt_q != '0) begin
              cur_d       = '0;
              mem_raddr_o = '0;
              res_ok_d    = 1'b1;
              state_d     = ST_RD_WAIT;
            end
          end
          OP_NEXT: begin
            cur_d = CW'(cur_nxt_p);
            if (cur_nxt_p < cnt_p) begin
              mem_raddr_o = AW'(cur_nxt_p);
              res_ok_d    = 1'b1;
              state_d     = ST_RD_WAIT;
            end
          end
          OP_RESTORE: begin
            cur_d = CW'(cur_rst_p);
            if (cur_rst_p < cnt_p) begin
              mem_raddr_o = AW'(cur_rst_p);
              res_ok_d    = 1'b1;
              state_d     = ST_RD_WAIT;
            end
          end
          default: begin
          end
        endcase
      end

      // Moves the entry fetched last cycle up by one, fetching the next lower one.
      ST_SHIFT_UP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q;
        mem_wdata_o = mem_rdata_i;
        if (ptr_p > idx_p + PW'(1)) begin
          mem_raddr_o = AW'(ptr_p - PW'(2));
          ptr_d       = AW'(ptr_p - PW'(1));
        end else begin
          state_d = ST_INS_WR;
        end
      end

      ST_INS_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AW'(idx_q);
        mem_wdata_o = value_q;
        cnt_d       = cnt_q + CW'(1);
        res_ok_d    = 1'b1;
        state_d     = ST_DONE;
      end

      // The read data belongs to the entry at ptr_q.
      ST_SEARCH: begin
        if (mem_rdata_i == value_q) begin
          state_d = ST_DEL_START;
        end else if (ptr_p + PW'(1) < cnt_p) begin
          mem_raddr_o = AW'(ptr_p + PW'(1));
          ptr_d       = AW'(ptr_p + PW'(1));
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_DEL_START: begin
        if (ptr_p + PW'(1) == cnt_p) begin
          cnt_d    = cnt_q - CW'(1);
          res_ok_d = 1'b1;
          state_d  = ST_DONE;
        end else begin
          mem_raddr_o = AW'(ptr_p + PW'(1));
          state_d     = ST_SHIFT_DN;
        end
      end

      ST_SHIFT_DN: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q;
        mem_wdata_o = mem_rdata_i;
        if (ptr_p + PW'(2) < cnt_p) begin
          mem_raddr_o = AW'(ptr_p + PW'(2));
          ptr_d       = AW'(ptr_p + PW'(1));
        end else begin
          cnt_d    = cnt_q - CW'(1);
          res_ok_d = 1'b1;
          state_d  = ST_DONE;
        end
      end

      ST_RD_WAIT: begin
        res_item_d = mem_rdata_i;
        state_d    = ST_DONE;
      end

      // Waits for the output register to be free, then hands the result over.
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_item_d  = res_item_q;
          out_saved_d = res_saved_q;
          out_count_d = FIELD_W'(cnt_q);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    value_q     <= value_d;
    idx_q       <= idx_d;
    ptr_q       <= ptr_d;
    res_ok_q    <= res_ok_d;
    res_item_q  <= res_item_d;
    res_saved_q <= res_saved_d;
    out_ok_q    <= out_ok_d;
    out_item_q  <= out_item_d;
    out_saved_q <= out_saved_d;
    out_count_q <= out_count_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_ok_o    = out_ok_q;
  assign out_item_o  = out_item_q;
  assign out_saved_o = out_saved_q;
  assign out_count_o = out_count_q;

endmodule

`default_nettype wire

// ===== sv/ordered_list_engine_top.sv =====
// Ordered list engine: a packed list of up to DEPTH 64-bit words plus a read cursor.
// Commands arrive on the s_axis channel, one transfer per command; each command
// returns exactly one result transfer on the m_axis channel, in order.
// Insert and delete shift the entries above the index one by one, and delete by
// value first searches the entries one by one up to the match; get and cursor
// commands add a memory read to the path that append and clear take.
// The memory has one write port and one read port, and every shifted or
// searched entry takes its own step through them.
// s_axis_tready_o is high only while the sequencer is idle, so one command is
// in work at a time. A finished result sits in an output register; the next
// command is taken while it waits, and the sequencer holds its own result
// until the receiver has taken the earlier one, so a stall loses nothing.
// Reset empties the list and zeroes the cursor; stored words are left as they
// were and are never read before being written again.
`default_nettype none

module ordered_list_engine_top #(
  parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // Fields from bit 0: opcode[3:0], value[67:4], index[76:68], zero pad.
  input  wire logic [ole_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // Fields from bit 0: ok[0], item[64:1], saved_cursor[73:65], count[82:74], zero pad.
  output logic      [ole_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import ole_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [OP_W-1:0]    in_opcode;
  logic [WORD_W-1:0]  in_value;
  logic [FIELD_W-1:0] in_index;
  logic               out_ok;
  logic [WORD_W-1:0]  out_item;
  logic [FIELD_W-1:0] out_saved;
  logic [FIELD_W-1:0] out_count;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [WORD_W-1:0]  mem_rdata;

  assign in_opcode = s_axis_tdata_i[OP_W-1:0];
  assign in_value  = s_axis_tdata_i[OP_W +: WORD_W];
  assign in_index  = s_axis_tdata_i[OP_W+WORD_W +: FIELD_W];

  assign m_axis_tdata_o = {(OUT_TDATA_W - OUT_BITS)'(0), out_count, out_saved, out_item, out_ok};

  ole_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_opcode_i (in_opcode),
    .in_value_i  (in_value),
    .in_index_i  (in_index),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_ok_o    (out_ok),
    .out_item_o  (out_item),
    .out_saved_o (out_saved),
    .out_count_o (out_count),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ole_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== sv/ole_checker.sv =====
`default_nettype none

module ole_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid_i,
  input wire logic                            s_axis_tready_o,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [ole_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import ole_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result payload changed while stalled");

  // Every command passes through further states, so the block is busy right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command taken in back-to-back cycles");

  // A failed command never returns a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[WORD_W:1] == '0)
    else $error("item nonzero on a failed command");

endmodule

bind ordered_list_engine_top ole_checker u_ole_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ole_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 950;
  localparam int MAX_REPORTS  = 10;
  localparam int MAX_GAP      = 12;
  // Far beyond the slowest legal run: every command shifting a full list
  // while both sides stall.
  localparam int TIMEOUT_NS   = 60_000_000;

  // Opcodes with no function; the block must answer them with ok=0.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic               ok;
    logic [WORD_W-1:0]  item;
    logic [FIELD_W-1:0] saved;
    logic [FIELD_W-1:0] count;
  } list_result_t;

  class list_scoreboard;
    logic [WORD_W-1:0] words[LIST_DEPTH];
    int unsigned       n_words;
    int unsigned       cur;
    list_result_t      pending_results[$];
    int                mismatches;

    function new();
      foreach (words[i]) words[i] = '0;
      n_words    = 0;
      cur        = 0;
      mismatches = 0;
    endfunction

    function bit read_at_cursor(output logic [WORD_W-1:0] w);
      w = '0;
      if (cur >= n_words) return 1'b0;
      w = words[cur];
      return 1'b1;
    endfunction

    function bit start_walk(output logic [WORD_W-1:0] w);
      w = '0;
      if (n_words == 0) return 1'b0;
      cur = 0;
      w   = words[0];
      return 1'b1;
    endfunction

    // Applies one accepted command to the shadow list and queues its result.
    function void note_command(logic [OP_W-1:0] op, logic [WORD_W-1:0] val,
                               logic [FIELD_W-1:0] idx);
      list_result_t r;
      int           k;
      int           pos;
      r = '0;
      case (op)
        OP_APPEND: begin
          if (n_words < LIST_DEPTH) begin
            words[n_words] = val;
            n_words++;
            r.ok = 1'b1;
          end
        end
        OP_INSERT: begin
          if (idx <= n_words && n_words < LIST_DEPTH) begin
            for (k = n_words; k > idx; k--) words[k] = words[k-1];
            words[idx] = val;
            n_words++;
            r.ok = 1'b1;
          end
        end
        OP_GET: begin
          if (idx < n_words) begin
            r.item = words[idx];
            r.ok   = 1'b1;
          end
        end
        OP_DELETE: begin
          if (n_words != 0 && idx < n_words) begin
            pos = -1;
            if (val == '0) begin
              pos = int'(idx);
            end else begin
              for (k = 0; k < n_words && pos < 0; k++)
                if (words[k] == val) pos = k;
            end
            if (pos >= 0) begin
              for (k = pos; k + 1 < n_words; k++) words[k] = words[k+1];
              n_words--;
              r.ok = 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          n_words = 0;
          r.ok    = 1'b1;
        end
        OP_START: r.ok = start_walk(r.item);
        OP_NEXT: begin
          if (cur < LIST_DEPTH) cur++;
          r.ok = read_at_cursor(r.item);
        end
        OP_SAVE: begin
          r.saved = cur[FIELD_W-1:0];
          r.ok    = start_walk(r.item);
        end
        OP_RESTORE: begin
          cur  = (idx > LIST_DEPTH) ? LIST_DEPTH : idx;
          r.ok = read_at_cursor(r.item);
        end
        default: ;
      endcase
      r.count = n_words[FIELD_W-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      list_result_t got;
      list_result_t want;
      got = {data[0], data[64:1], data[73:65], data[82:74]};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result transfer: ok=%0b item=%h saved=%0d count=%0d",
                   got.ok, got.item, got.saved, got.count);
        return;
      end
      want = pending_results.pop_front();
      if (got.ok !== want.ok || got.item !== want.item ||
          got.saved !== want.saved || got.count !== want.count) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $write("Result mismatch: expected ok=%0b item=%h saved=%0d count=%0d",
                 want.ok, want.item, want.saved, want.count);
          $display(", got ok=%0b item=%h saved=%0d count=%0d",
                   got.ok, got.item, got.saved, got.count);
        end
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  list_scoreboard sb;
  int             sent = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;

  ordered_list_engine_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Drives one command and records it in the shadow list on its transfer.
  task automatic send_command(logic [OP_W-1:0] op, logic [WORD_W-1:0] val,
                              logic [FIELD_W-1:0] idx);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({idx, val, op});
    do @(posedge clk_i); while (!s_tready);
    sb.note_command(op, val, idx);
    sent++;
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    if (sb.n_words > 0 && $urandom_range(4) == 0)
      return sb.words[$urandom_range(0, sb.n_words - 1)];
    return {$urandom, $urandom};
  endfunction

  // Mostly a legal position up to bound, sometimes anywhere from 0 to LIST_DEPTH.
  function automatic logic [FIELD_W-1:0] pick_index(int unsigned bound);
    if ($urandom_range(99) < 85) return FIELD_W'($urandom_range(0, bound));
    return FIELD_W'($urandom_range(0, LIST_DEPTH));
  endfunction

  function automatic int unsigned last_pos();
    return (sb.n_words == 0) ? 0 : sb.n_words - 1;
  endfunction

  task automatic fill_list();
    while (sb.n_words < LIST_DEPTH) begin
      if ($urandom_range(1)) send_command(OP_APPEND, pick_word(), '0);
      else send_command(OP_INSERT, pick_word(), pick_index(sb.n_words));
    end
    send_command(OP_APPEND, pick_word(), '0);
    send_command(OP_INSERT, pick_word(), FIELD_W'($urandom_range(0, LIST_DEPTH)));
  endtask

  task automatic random_burst();
    int               kind;
    int               n;
    logic [OP_W-1:0]  op;
    logic [WORD_W-1:0] v;
    kind = $urandom_range(99);
    if (kind < 30) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        if ($urandom_range(1)) send_command(OP_APPEND, pick_word(), pick_index(sb.n_words));
        else send_command(OP_INSERT, pick_word(), pick_index(sb.n_words));
      end
    end else if (kind < 50) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(99) < 60) v = '0;
        else if (sb.n_words > 0 && $urandom_range(3) != 0)
          v = sb.words[$urandom_range(0, last_pos())];
        else v = {$urandom, $urandom};
        send_command(OP_DELETE, v, pick_index(last_pos()));
      end
    end else if (kind < 65) begin
      n = $urandom_range(1, 4);
      repeat (n) send_command(OP_GET, {$urandom, $urandom}, pick_index(last_pos()));
    end else if (kind < 85) begin
      if ($urandom_range(1)) send_command(OP_START, {$urandom, $urandom}, pick_index(LIST_DEPTH));
      else send_command(OP_SAVE, {$urandom, $urandom}, pick_index(LIST_DEPTH));
      n = $urandom_range(1, 6);
      repeat (n) send_command(OP_NEXT, {$urandom, $urandom}, pick_index(LIST_DEPTH));
      if ($urandom_range(99) < 30)
        send_command(OP_RESTORE, {$urandom, $urandom},
                     ($urandom_range(3) == 0) ? FIELD_W'(LIST_DEPTH)
                                              : pick_index(sb.n_words));
    end else if (kind < 95) begin
      if ($urandom_range(9) == 0) op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else op = OP_W'($urandom_range(OP_APPEND, OP_RESTORE));
      send_command(op, {$urandom, $urandom}, FIELD_W'($urandom_range(0, LIST_DEPTH)));
    end else if (kind < 97) begin
      send_command(OP_CLEAR, {$urandom, $urandom}, pick_index(LIST_DEPTH));
    end else begin
      fill_list();
    end
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin
    sb = new();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty list: every read, delete and walk fails; save still reports the cursor.
    send_command(OP_GET, '0, 9'd0);
    send_command(OP_DELETE, '0, 9'd0);
    send_command(OP_START, '0, 9'd0);
    send_command(OP_RESTORE, '0, 9'd5);
    send_command(OP_SAVE, '0, 9'd0);
    send_command(OP_INSERT, 64'h1, 9'd1);
    // Build a short list through both ends and the middle.
    send_command(OP_APPEND, '1, 9'd0);
    send_command(OP_APPEND, '0, 9'd0);
    send_command(OP_INSERT, 64'h8000_0000_0000_0001, 9'd0);
    send_command(OP_INSERT, 64'h5555_5555_5555_5555, 9'd3);
    send_command(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 9'd2);
    send_command(OP_GET, '0, 9'd4);
    send_command(OP_GET, '0, 9'd256);
    // Cursor walk, save-and-restart, saturation at the top.
    send_command(OP_START, '0, 9'd0);
    send_command(OP_NEXT, '0, 9'd0);
    send_command(OP_NEXT, '0, 9'd0);
    send_command(OP_SAVE, '0, 9'd0);
    send_command(OP_RESTORE, '0, 9'd256);
    send_command(OP_NEXT, '0, 9'd0);
    send_command(OP_RESTORE, '0, 9'd3);
    // Delete by value (hit, miss, index out of range) and by index.
    send_command(OP_DELETE, 64'hAAAA_AAAA_AAAA_AAAA, 9'd0);
    send_command(OP_DELETE, 64'h1234, 9'd0);
    send_command(OP_DELETE, '1, 9'd4);
    send_command(OP_DELETE, '0, 9'd3);
    send_command(OP_UNUSED_LO, '1, 9'd0);
    send_command(OP_UNUSED_HI, '1, 9'd256);
    send_command(OP_CLEAR, '0, 9'd0);
    send_command(OP_GET, '0, 9'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      // In phases 1 and 3 the list is driven to full, then overflowed.
      if (phase == 1 || phase == 3) fill_list();
      while (sent < 26 + (phase + 1) * RANDOM_ITEMS / 4) random_burst();
    end

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (LIST_DEPTH + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== ordered_list_engine_top.f =====
sv/ole_pkg.sv
sv/ole_mem.sv
sv/ole_seq.sv
sv/ordered_list_engine_top.sv
sv/ole_checker.sv
verif/tb.sv
